[rtl/core/ishx_pkg.sv]
package ishx_pkg;

    localparam logic [31:0] SHA_IV0 = 32'h67452301;
    localparam logic [31:0] SHA_IV1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_IV2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_IV3 = 32'h10325476;
    localparam logic [31:0] SHA_IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] SHA_K0 = 32'h5A827999;
    localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] HEX_BITS = 32'd320;

    localparam logic [0:0] REG_REPEAT = 1'b0;
    localparam logic [0:0] REG_HEXUP  = 1'b1;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? 8'h41 : 8'h61;
            hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (base + {4'd0, nib} - 8'd10);
        end
    endfunction

    function automatic logic [31:0] hex4(input logic [15:0] v, input logic upper);
        hex4 = {hex_char(v[15:12], upper), hex_char(v[11:8], upper),
                hex_char(v[7:4], upper), hex_char(v[3:0], upper)};
    endfunction

endpackage

[rtl/core/iterated_sha1_hex_digest.sv]
// Sequence: a compression is 80 rounds (ST_ROUND) and one add (ST_ADD); a last item
// adds a pad step, a length step, one or two compressions and, per repeat pass, a hex
// step and a compression before the first of five results.
// Throughput: one message byte per cycle while idle; input stalls while each 64-byte
// block compresses (one shared round unit, one round per cycle, 16-word schedule).
// Reset: synchronous, active low; chain value returns to the SHA-1 initial
// constants, repeat_count to 1 and hex_upper to 0.
module iterated_sha1_hex_digest
    import ishx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // digest_word, hex_chars
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_LEN, ST_HEX, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        NX_IN, NX_PAD, NX_LEN, NX_PASS
    } after_t;

    state_t         state_reg;
    after_t         after_reg;
    logic [31:0]    repeat_reg;
    logic           upper_reg;
    logic [31:0]    cv_reg [5];
    logic [31:0]    w_reg [16];
    logic [31:0]    a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]    total_reg;
    logic [6:0]     round_reg;
    logic [31:0]    pass_reg;
    logic [2:0]     out_reg;

    logic           wr_en;
    logic [31:0]    f_val, k_val, t_val, w_new;
    logic [5:0]     pos;
    logic [1:0]     bsel;
    logic [31:0]    cv_out;
    logic [31:0]    pass_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEXUP) ? {31'd0, upper_reg} : repeat_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign pos      = total_reg[5:0];
    assign bsel     = pos[1:0];

    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = SHA_K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA_K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = SHA_K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA_K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_reg[0] + k_val;
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    assign cv_out    = cv_reg[out_reg];
    assign pass_next = pass_reg + 32'd1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {hex4(cv_out[31:16], upper_reg), hex4(cv_out[15:0], upper_reg),
                        cv_out};
    assign m_tlast   = (out_reg == 3'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            after_reg    <= NX_IN;
            repeat_reg   <= 32'd1;
            upper_reg    <= 1'b0;
            cv_reg[0]    <= SHA_IV0;
            cv_reg[1]    <= SHA_IV1;
            cv_reg[2]    <= SHA_IV2;
            cv_reg[3]    <= SHA_IV3;
            cv_reg[4]    <= SHA_IV4;
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            d_reg        <= '0;
            e_reg        <= '0;
            total_reg    <= '0;
            round_reg    <= '0;
            pass_reg     <= '0;
            out_reg      <= '0;
        end else begin
            if (wr_en) begin
                if (paddr[2] == REG_REPEAT) begin
                    repeat_reg <= pwdata;
                end else begin
                    upper_reg <= pwdata[0];
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser) begin
                            case (bsel)
                                2'd0: w_reg[pos[5:2]] <= {s_tdata, 24'd0};
                                2'd1: w_reg[pos[5:2]][23:16] <= s_tdata;
                                2'd2: w_reg[pos[5:2]][15:8] <= s_tdata;
                                default: w_reg[pos[5:2]][7:0] <= s_tdata;
                            endcase
                            total_reg <= total_reg + 32'd1;
                        end
                        if (s_tuser && pos == 6'd63) begin
                            state_reg <= ST_ROUND;
                            after_reg <= s_tlast ? NX_PAD : NX_IN;
                            a_reg <= cv_reg[0]; b_reg <= cv_reg[1]; c_reg <= cv_reg[2];
                            d_reg <= cv_reg[3]; e_reg <= cv_reg[4];
                            round_reg <= '0;
                        end else if (s_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // append 0x80 and clear the rest of the block
                    for (int i = 0; i < 16; i++) begin
                        if (4'(i) > pos[5:2]) w_reg[i] <= '0;
                    end
                    case (bsel)
                        2'd0: w_reg[pos[5:2]] <= {PAD_BYTE, 24'd0};
                        2'd1: w_reg[pos[5:2]][23:0] <= {PAD_BYTE, 16'd0};
                        2'd2: w_reg[pos[5:2]][15:0] <= {PAD_BYTE, 8'd0};
                        default: w_reg[pos[5:2]][7:0] <= PAD_BYTE;
                    endcase
                    if (pos >= 6'd56) begin
                        state_reg <= ST_ROUND;
                        after_reg <= NX_LEN;
                        a_reg <= cv_reg[0]; b_reg <= cv_reg[1]; c_reg <= cv_reg[2];
                        d_reg <= cv_reg[3]; e_reg <= cv_reg[4];
                        round_reg <= '0;
                    end else begin
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (after_reg == NX_LEN) begin
                        for (int i = 0; i < 14; i++) w_reg[i] <= '0;
                    end
                    w_reg[14] <= {29'd0, total_reg[31:29]};
                    w_reg[15] <= {total_reg[28:0], 3'd0};
                    state_reg <= ST_ROUND;
                    after_reg <= NX_PASS;
                    a_reg <= cv_reg[0]; b_reg <= cv_reg[1]; c_reg <= cv_reg[2];
                    d_reg <= cv_reg[3]; e_reg <= cv_reg[4];
                    round_reg <= '0;
                    pass_reg <= 32'd1;
                end
                ST_ROUND: begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t_val;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= w_new;
                    if (round_reg == 7'd79) begin
                        state_reg <= ST_ADD;
                        round_reg <= '0;
                    end else begin
                        round_reg <= round_reg + 7'd1;
                    end
                end
                ST_ADD: begin
                    cv_reg[0] <= cv_reg[0] + a_reg;
                    cv_reg[1] <= cv_reg[1] + b_reg;
                    cv_reg[2] <= cv_reg[2] + c_reg;
                    cv_reg[3] <= cv_reg[3] + d_reg;
                    cv_reg[4] <= cv_reg[4] + e_reg;
                    case (after_reg)
                        NX_IN:   state_reg <= ST_IDLE;
                        NX_PAD:  state_reg <= ST_PAD;
                        NX_LEN:  state_reg <= ST_LEN;
                        default: state_reg <= (pass_reg < repeat_reg) ? ST_HEX : ST_OUT;
                    endcase
                    out_reg <= '0;
                end
                ST_HEX: begin
                    for (int j = 0; j < 5; j++) begin
                        w_reg[2 * j]     <= hex4(cv_reg[j][31:16], upper_reg);
                        w_reg[2 * j + 1] <= hex4(cv_reg[j][15:0], upper_reg);
                    end
                    w_reg[10] <= 32'h80000000;
                    w_reg[11] <= '0;
                    w_reg[12] <= '0;
                    w_reg[13] <= '0;
                    w_reg[14] <= '0;
                    w_reg[15] <= HEX_BITS;
                    cv_reg[0] <= SHA_IV0; cv_reg[1] <= SHA_IV1; cv_reg[2] <= SHA_IV2;
                    cv_reg[3] <= SHA_IV3; cv_reg[4] <= SHA_IV4;
                    a_reg <= SHA_IV0; b_reg <= SHA_IV1; c_reg <= SHA_IV2;
                    d_reg <= SHA_IV3; e_reg <= SHA_IV4;
                    round_reg <= '0;
                    pass_reg  <= pass_next;
                    after_reg <= NX_PASS;
                    state_reg <= ST_ROUND;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (out_reg == 3'd4) begin
                            state_reg <= ST_IDLE;
                            after_reg <= NX_IN;
                            cv_reg[0] <= SHA_IV0; cv_reg[1] <= SHA_IV1;
                            cv_reg[2] <= SHA_IV2; cv_reg[3] <= SHA_IV3;
                            cv_reg[4] <= SHA_IV4;
                            total_reg <= '0;
                            pass_reg  <= '0;
                            out_reg   <= '0;
                        end else begin
                            out_reg <= out_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[dv/iterated_sha1_hex_digest_chk.sv]
`timescale 1ns / 1ps

module iterated_sha1_hex_digest_chk
    import ishx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // last_item
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // digest_word, hex_chars
    input  logic        m_tlast,   // last_word
    output int          pending,
    output int          errors,
    output int          digests_seen
);

    logic [31:0] pass_total;
    logic        upper_case;
    logic [31:0] chain_h [5];
    logic [31:0] msg_blk [16];
    logic [31:0] byte_cnt;

    logic [31:0] digest_q [$];
    logic [63:0] hex_q [$];
    logic        tail_q [$];

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib, input logic up);
        if (nib < 4'd10) return 8'h30 + nib;
        return (up ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [31:0] ascii4(input logic [15:0] v, input logic up);
        return {nibble_ascii(v[15:12], up), nibble_ascii(v[11:8], up),
                nibble_ascii(v[7:4], up), nibble_ascii(v[3:0], up)};
    endfunction

    function automatic void load_iv();
        chain_h[0] = SHA_IV0;
        chain_h[1] = SHA_IV1;
        chain_h[2] = SHA_IV2;
        chain_h[3] = SHA_IV3;
        chain_h[4] = SHA_IV4;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
        for (int i = 16; i < 80; i++) begin
            x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = SHA_K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = SHA_K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = SHA_K2;
            end else begin
                f = b ^ c ^ d; k = SHA_K3;
            end
            t = {a[26:0], a[31:27]} + f + e + w[i] + k;
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
        chain_h[3] += d; chain_h[4] += e;
    endfunction

    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] val);
        int idx;
        int sh;
        idx = pos >> 2;
        sh = 24 - 8 * pos[1:0];
        if (pos[1:0] == 2'd0) msg_blk[idx] = '0;
        msg_blk[idx][sh +: 8] = val;
    endfunction

    function automatic void close_message();
        logic [5:0] pos;
        pos = byte_cnt[5:0];
        place_byte(pos, PAD_BYTE);
        for (int i = (pos >> 2) + 1; i < 16; i++) msg_blk[i] = '0;
        if (pos >= 6'd56) begin
            sha_compress();
            for (int i = 0; i < 16; i++) msg_blk[i] = '0;
        end
        msg_blk[14] = byte_cnt >> 29;
        msg_blk[15] = byte_cnt << 3;
        sha_compress();
    endfunction

    function automatic void rehash_ascii();
        logic [31:0] prev [5];
        for (int j = 0; j < 5; j++) prev[j] = chain_h[j];
        for (int j = 0; j < 5; j++) begin
            msg_blk[2*j]   = ascii4(prev[j][31:16], upper_case);
            msg_blk[2*j+1] = ascii4(prev[j][15:0], upper_case);
        end
        msg_blk[10] = 32'h80000000;
        for (int i = 11; i < 15; i++) msg_blk[i] = '0;
        msg_blk[15] = HEX_BITS;
        load_iv();
        sha_compress();
    endfunction

    function automatic void absorb_request(input logic [7:0] val, input logic present,
                                           input logic last);
        logic [5:0] pos;
        if (present) begin
            pos = byte_cnt[5:0];
            place_byte(pos, val);
            byte_cnt++;
            if (pos == 6'd63) sha_compress();
        end
        if (!last) return;
        close_message();
        for (longint p = 1; p < pass_total; p++) rehash_ascii();
        for (int j = 0; j < 5; j++) begin
            digest_q.push_back(chain_h[j]);
            hex_q.push_back({ascii4(chain_h[j][31:16], upper_case),
                             ascii4(chain_h[j][15:0], upper_case)});
            tail_q.push_back(j == 4);
        end
        load_iv();
        byte_cnt = '0;
    endfunction

    initial begin
        errors = 0;
        digests_seen = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            pass_total = 32'd1;
            upper_case = 1'b0;
            load_iv();
            byte_cnt = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_REPEAT) pass_total = pwdata;
                else upper_case = pwdata[0];
            end
            if (s_tvalid && s_tready) absorb_request(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected result: digest_word %h", m_tdata[31:0]);
                    errors++;
                end else begin
                    if (m_tdata[31:0] !== digest_q[0]) begin
                        $error("digest_word: expected %h, actual %h",
                               digest_q[0], m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[95:32] !== hex_q[0]) begin
                        $error("hex_chars: expected %h, actual %h", hex_q[0], m_tdata[95:32]);
                        errors++;
                    end
                    if (m_tlast !== tail_q[0]) begin
                        $error("last_word: expected %b, actual %b", tail_q[0], m_tlast);
                        errors++;
                    end
                    if (tail_q[0]) digests_seen++;
                    void'(digest_q.pop_front());
                    void'(hex_q.pop_front());
                    void'(tail_q.pop_front());
                end
            end
        end
        pending = digest_q.size();
    end

endmodule

[dv/iterated_sha1_hex_digest_tb.sv]
`timescale 1ns / 1ps

module iterated_sha1_hex_digest_tb;
    import ishx_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // data_byte
    logic        s_tuser = 1'b0; // byte_present
    logic        s_tlast = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // digest_word, hex_chars
    logic        m_tlast;        // last_word

    int pending;
    int errors;
    int digests_seen;
    int cycles = 0;
    int src_idle = 0;
    int dst_idle = 0;
    int bytes_sent = 0;

    always #1 aclk = ~aclk;

    iterated_sha1_hex_digest uut (.*);

    iterated_sha1_hex_digest_chk chk (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= dst_idle);

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_request(input logic [7:0] val, input logic present, input logic last);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= val; s_tuser <= present; s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (present) bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message(input int len);
        logic ended;
        ended = 1'b0;
        for (int i = 0; i < len; i++) begin
            // sprinkle idle requests as noise
            if ($urandom_range(15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1)) begin
                send_request(8'($urandom), 1'b1, 1'b1);
                ended = 1'b1;
            end else begin
                send_request(8'($urandom), 1'b1, 1'b0);
            end
        end
        if (!ended) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic random_phase(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: len = 55;
                1: len = 56;
                2: len = 63 + $urandom_range(1);
                3: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            send_message(len);
            sent += len + 1;
            if ($urandom_range(7) == 0) begin
                // hold until every digest has drained
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        src_idle = 21; dst_idle = 48;

        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h55, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hAA, 1'b0, 1'b1);
        settle();

        reg_write(REG_REPEAT, 32'hFFFFFFFF);
        reg_write(REG_REPEAT, 32'd0);
        reg_write(REG_HEXUP, 32'd1);
        send_request(8'hFF, 1'b1, 1'b1);
        random_phase(60);
        settle();

        reg_write(REG_REPEAT, 32'd3);
        reg_write(REG_HEXUP, 32'd0);
        src_idle = 48; dst_idle = 21;
        random_phase(90);
        settle();

        reg_write(REG_REPEAT, 32'd2);
        reg_write(REG_HEXUP, 32'd1);
        src_idle = 0; dst_idle = 0;
        random_phase(100);
        settle();

        $display("Covered %0d message bytes, %0d digests, repeat counts 0..3, both hex cases.",
                 bytes_sent, digests_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
